### src/hufc_pkg.sv
`timescale 1ns / 1ps
package hufc_pkg;

  // Table geometry and code sizes
  localparam int SYM_BITS    = 8;
  localparam int TABLE_DEPTH = 1 << SYM_BITS;
  localparam int CODE_W      = 32;
  localparam int CHUNK_W     = 16;
  localparam int LEN_W       = $clog2(CODE_W + 1);
  localparam int CLEN_W      = $clog2(CHUNK_W + 1);
  localparam int SYM_FIELD_W = 8;
  localparam int COUNT_W     = 32;

  typedef logic [SYM_BITS-1:0]    sym_t;
  typedef logic [CODE_W-1:0]      code_t;
  typedef logic [LEN_W-1:0]       len_t;
  typedef logic [CHUNK_W-1:0]     chunk_t;
  typedef logic [CLEN_W-1:0]      clen_t;
  typedef logic [SYM_FIELD_W-1:0] sym_field_t;
  typedef logic [COUNT_W-1:0]     count_t;

  localparam len_t CODE_LEN_FULL = len_t'(CODE_W);
  localparam len_t CHUNK_LEN     = len_t'(CHUNK_W);

  // Action codes
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_ENCODE = 2'd1;
  localparam logic [1:0] ACT_START  = 2'd2;
  localparam logic [1:0] ACT_BIT    = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_CHUNK  = 2'd0;
  localparam logic [1:0] KIND_SYMBOL = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    sym_field_t symbol;
    code_t      code_bits;
    len_t       code_len;
    logic       bit_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    chunk_t     chunk_bits;
    clen_t      chunk_len;
    logic       last_chunk;
    sym_field_t symbol_out;
    count_t     symbols_left;
  } out_item_t;

  typedef struct packed {
    len_t  len;
    code_t bits;
  } entry_t;

  // Table port controls from the sequencer
  typedef struct packed {
    logic   wr_en;
    sym_t   wr_addr;
    entry_t wr_entry;
    logic   rd_en;
    sym_t   rd_addr;
  } tbl_req_t;

endpackage

### src/hufc_table.sv
`timescale 1ns / 1ps
module hufc_table (
  input  logic              clk,
  input  logic              rst_n,
  input  hufc_pkg::tbl_req_t req,
  output hufc_pkg::entry_t  rd_entry
);

  hufc_pkg::entry_t                   mem [hufc_pkg::TABLE_DEPTH];
  logic [hufc_pkg::TABLE_DEPTH-1:0]   valid_r;
  hufc_pkg::entry_t                   rd_data_r;
  logic                               rd_valid_r;

  // Write the code store
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_entry;
    end
  end

  // Track written entries; reset marks every symbol absent
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.wr_addr] <= 1'b1;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r  <= mem[req.rd_addr];
      rd_valid_r <= valid_r[req.rd_addr];
    end
  end

  // An unwritten entry reads as length zero
  assign rd_entry = rd_valid_r ? rd_data_r : '0;

endmodule

### src/hufc_match.sv
`timescale 1ns / 1ps
module hufc_match (
  input  hufc_pkg::entry_t entry,
  input  hufc_pkg::len_t   prefix_len,
  input  hufc_pkg::code_t  prefix_bits,
  output logic             hit
);

  // Compare one table entry against the current prefix
  assign hit = (entry.len != '0) && (entry.len == prefix_len) &&
               (entry.bits == prefix_bits);

endmodule

### src/huffman_table_codec_core.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   hufc_pkg::in_item_t
// out_     output     out_valid/out_stall hufc_pkg::out_item_t
// cfg_     input      cfg_valid/cfg_ready symbol_count (32 bits)
//
// Load, start-decode and an ignored decode bit leave the core idle; encode reads the
// table, then for a present symbol sends its code as 16-bit chunks, each held while stalled.
// A decode bit makes 256 table reads through the shared match compare, drains the last
// read and then posts a symbol or an overflow error if either results.
// Synchronous reset clears the table valid bits, prefix and counters. in_stall is
// high while an item is in progress; a stalled result delays the next one posted.
module huffman_table_codec_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  hufc_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output hufc_pkg::out_item_t  out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  hufc_pkg::count_t     cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENC_RD,
    ST_ENC_OUT,
    ST_SCAN,
    ST_DRAIN,
    ST_DEC_OUT
  } state_t;

  state_t                 state_r, state_nxt;
  logic                   out_valid_r, out_valid_nxt;
  hufc_pkg::out_item_t    out_item_r, out_item_nxt;
  hufc_pkg::count_t       symbol_count_r, symbol_count_nxt;
  hufc_pkg::count_t       remaining_r, remaining_nxt;
  hufc_pkg::code_t        prefix_bits_r, prefix_bits_nxt;
  hufc_pkg::len_t         prefix_len_r, prefix_len_nxt;
  hufc_pkg::code_t        word_r, word_nxt;
  hufc_pkg::len_t         rem_len_r, rem_len_nxt;
  hufc_pkg::sym_t         scan_addr_r, scan_addr_nxt;
  logic                   cmp_v_r, cmp_v_nxt;
  hufc_pkg::sym_t         cmp_idx_r, cmp_idx_nxt;
  logic                   found_r, found_nxt;
  hufc_pkg::sym_t         hit_sym_r, hit_sym_nxt;

  hufc_pkg::tbl_req_t     tbl_req;
  hufc_pkg::entry_t       rd_entry;
  logic                   entry_hit;
  logic                   in_acc;
  logic                   out_free;
  hufc_pkg::len_t         take_w;
  hufc_pkg::len_t         load_len;
  hufc_pkg::sym_t         in_sym;

  hufc_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (tbl_req),
    .rd_entry (rd_entry)
  );

  hufc_match u_match (
    .entry       (rd_entry),
    .prefix_len  (prefix_len_r),
    .prefix_bits (prefix_bits_r),
    .hit         (entry_hit)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign cfg_ready = 1'b1;
  assign in_sym    = in_item.symbol[hufc_pkg::SYM_BITS-1:0];

  // Saturate the loaded length; size the next chunk
  assign load_len = (in_item.code_len > hufc_pkg::CODE_LEN_FULL) ?
                    hufc_pkg::CODE_LEN_FULL : in_item.code_len;
  assign take_w   = (rem_len_r > hufc_pkg::CHUNK_LEN) ? hufc_pkg::CHUNK_LEN : rem_len_r;

  // Sequencer next state
  always_comb begin
    state_nxt        = state_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_item_nxt     = out_item_r;
    symbol_count_nxt = cfg_valid ? cfg_data : symbol_count_r;
    remaining_nxt    = remaining_r;
    prefix_bits_nxt  = prefix_bits_r;
    prefix_len_nxt   = prefix_len_r;
    word_nxt         = word_r;
    rem_len_nxt      = rem_len_r;
    scan_addr_nxt    = scan_addr_r;
    found_nxt        = found_r;
    hit_sym_nxt      = hit_sym_r;
    tbl_req          = '0;
    tbl_req.wr_addr  = in_sym;
    tbl_req.rd_addr  = scan_addr_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_item.action)
            hufc_pkg::ACT_LOAD: begin
              tbl_req.wr_en         = 1'b1;
              tbl_req.wr_entry.len  = load_len;
              tbl_req.wr_entry.bits = in_item.code_bits & ~({hufc_pkg::CODE_W{1'b1}} >> load_len);
            end
            hufc_pkg::ACT_ENCODE: begin
              tbl_req.rd_en   = 1'b1;
              tbl_req.rd_addr = in_sym;
              state_nxt       = ST_ENC_RD;
            end
            hufc_pkg::ACT_START: begin
              prefix_bits_nxt = '0;
              prefix_len_nxt  = '0;
              remaining_nxt   = symbol_count_r;
            end
            hufc_pkg::ACT_BIT: begin
              if (remaining_r != '0) begin
                if (in_item.bit_in && (prefix_len_r < hufc_pkg::CODE_LEN_FULL)) begin
                  prefix_bits_nxt = prefix_bits_r |
                                    ({1'b1, {(hufc_pkg::CODE_W-1){1'b0}}} >> prefix_len_r);
                end
                prefix_len_nxt = prefix_len_r + 1'b1;
                scan_addr_nxt  = '0;
                found_nxt      = 1'b0;
                state_nxt      = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_ENC_RD: begin
        word_nxt    = rd_entry.bits;
        rem_len_nxt = rd_entry.len;
        state_nxt   = (rd_entry.len == '0) ? ST_IDLE : ST_ENC_OUT;
      end

      ST_ENC_OUT: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt             = '0;
          out_item_nxt.result_kind = hufc_pkg::KIND_CHUNK;
          out_item_nxt.chunk_bits  =
            hufc_pkg::chunk_t'(word_r >> (hufc_pkg::CODE_LEN_FULL - take_w));
          out_item_nxt.chunk_len   = hufc_pkg::clen_t'(take_w);
          out_item_nxt.last_chunk  = (rem_len_r <= hufc_pkg::CHUNK_LEN);
          word_nxt                 = word_r << take_w;
          rem_len_nxt              = rem_len_r - take_w;
          if (rem_len_r <= hufc_pkg::CHUNK_LEN) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_SCAN: begin
        tbl_req.rd_en = 1'b1;
        scan_addr_nxt = scan_addr_r + 1'b1;
        if (scan_addr_r == {hufc_pkg::SYM_BITS{1'b1}}) begin
          state_nxt = ST_DRAIN;
        end
      end

      ST_DRAIN: begin
        state_nxt = ST_DEC_OUT;
      end

      ST_DEC_OUT: begin
        if (found_r) begin
          if (out_free) begin
            out_valid_nxt              = 1'b1;
            out_item_nxt               = '0;
            out_item_nxt.result_kind   = hufc_pkg::KIND_SYMBOL;
            out_item_nxt.symbol_out    = hufc_pkg::sym_field_t'(hit_sym_r);
            out_item_nxt.symbols_left  = remaining_r - 1'b1;
            remaining_nxt              = remaining_r - 1'b1;
            prefix_bits_nxt            = '0;
            prefix_len_nxt             = '0;
            state_nxt                  = ST_IDLE;
          end
        end else if (prefix_len_r >= hufc_pkg::CODE_LEN_FULL) begin
          if (out_free) begin
            out_valid_nxt              = 1'b1;
            out_item_nxt               = '0;
            out_item_nxt.result_kind   = hufc_pkg::KIND_ERROR;
            out_item_nxt.symbols_left  = remaining_r;
            prefix_bits_nxt            = '0;
            prefix_len_nxt             = '0;
            state_nxt                  = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Match stage: the read issued last cycle returns now; keep the highest hit
    cmp_v_nxt   = (state_r == ST_SCAN);
    cmp_idx_nxt = scan_addr_r;
    if (cmp_v_r && entry_hit) begin
      found_nxt   = 1'b1;
      hit_sym_nxt = cmp_idx_r;
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      out_valid_r    <= 1'b0;
      symbol_count_r <= '0;
      remaining_r    <= '0;
      prefix_bits_r  <= '0;
      prefix_len_r   <= '0;
      cmp_v_r        <= 1'b0;
      found_r        <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      out_valid_r    <= out_valid_nxt;
      symbol_count_r <= symbol_count_nxt;
      remaining_r    <= remaining_nxt;
      prefix_bits_r  <= prefix_bits_nxt;
      prefix_len_r   <= prefix_len_nxt;
      cmp_v_r        <= cmp_v_nxt;
      found_r        <= found_nxt;
    end
    out_item_r  <= out_item_nxt;
    word_r      <= word_nxt;
    rem_len_r   <= rem_len_nxt;
    scan_addr_r <= scan_addr_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    hit_sym_r   <= hit_sym_nxt;
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int RANDOM_ITEMS  = 1150;
  localparam int SETTLE_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  // Tracks the codec state and the results each accepted transaction should produce
  class codec_tracker;
    hufc_pkg::code_t     code_word_tab [hufc_pkg::TABLE_DEPTH];
    hufc_pkg::len_t      code_len_tab  [hufc_pkg::TABLE_DEPTH];
    hufc_pkg::code_t     prefix_word;
    int                  prefix_len;
    hufc_pkg::count_t    left;
    hufc_pkg::count_t    run_count;
    hufc_pkg::out_item_t due_results [$];
    int                  faults;

    function new();
      foreach (code_word_tab[i]) begin
        code_word_tab[i] = '0;
        code_len_tab[i]  = '0;
      end
      prefix_word = '0;
      prefix_len  = 0;
      left        = '0;
      run_count   = '0;
      faults      = 0;
    endfunction

    function void flag(string what);
      faults++;
      if (faults <= 10) $display("MISMATCH: %s", what);
    endfunction

    function void cmp_field(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) flag($sformatf("%s expected %0h got %0h", what, want, got));
    endfunction

    // Append one prediction at the tail
    function void queue_result(hufc_pkg::out_item_t r);
      due_results = {due_results, r};
    endfunction

    // Predict the results of one accepted input transaction
    function void take_item(hufc_pkg::in_item_t it);
      hufc_pkg::sym_t      s;
      int                  n;
      int                  sent;
      int                  take;
      int                  i;
      hufc_pkg::code_t     sh;
      bit                  found;
      hufc_pkg::sym_t      hit;
      hufc_pkg::out_item_t r;
      s = hufc_pkg::sym_t'(it.symbol);
      case (it.action)
        hufc_pkg::ACT_LOAD: begin
          // saturate the length and drop bits below the code
          n = (it.code_len > hufc_pkg::CODE_LEN_FULL) ? hufc_pkg::CODE_W : int'(it.code_len);
          code_len_tab[s]  = hufc_pkg::len_t'(n);
          code_word_tab[s] = it.code_bits & ~({hufc_pkg::CODE_W{1'b1}} >> n);
        end
        hufc_pkg::ACT_ENCODE: begin
          n    = int'(code_len_tab[s]);
          sent = 0;
          while (sent < n) begin
            take = (n - sent > hufc_pkg::CHUNK_W) ? hufc_pkg::CHUNK_W : n - sent;
            sh   = code_word_tab[s] << sent;
            r    = '0;
            r.result_kind = hufc_pkg::KIND_CHUNK;
            r.chunk_bits  = hufc_pkg::chunk_t'(sh >> (hufc_pkg::CODE_W - take));
            r.chunk_len   = hufc_pkg::clen_t'(take);
            sent += take;
            r.last_chunk  = (sent >= n);
            queue_result(r);
          end
        end
        hufc_pkg::ACT_START: begin
          prefix_word = '0;
          prefix_len  = 0;
          left        = run_count;
        end
        hufc_pkg::ACT_BIT: begin
          // ignore bits once the run has emitted all its symbols
          if (left != '0) begin
            if (it.bit_in && prefix_len < hufc_pkg::CODE_W)
              prefix_word[hufc_pkg::CODE_W-1-prefix_len] = 1'b1;
            prefix_len++;
            found = 1'b0;
            hit   = '0;
            // the highest matching symbol wins
            for (i = 0; i < hufc_pkg::TABLE_DEPTH; i++) begin
              if (code_len_tab[i] != '0 && int'(code_len_tab[i]) == prefix_len &&
                  code_word_tab[i] == prefix_word) begin
                found = 1'b1;
                hit   = hufc_pkg::sym_t'(i);
              end
            end
            r = '0;
            if (found) begin
              left--;
              prefix_word = '0;
              prefix_len  = 0;
              r.result_kind  = hufc_pkg::KIND_SYMBOL;
              r.symbol_out   = hit;
              r.symbols_left = left;
              queue_result(r);
            end else if (prefix_len >= hufc_pkg::CODE_W) begin
              prefix_word = '0;
              prefix_len  = 0;
              r.result_kind  = hufc_pkg::KIND_ERROR;
              r.symbols_left = left;
              queue_result(r);
            end
          end
        end
        default: begin
        end
      endcase
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(hufc_pkg::out_item_t got);
      hufc_pkg::out_item_t want;
      if (due_results.size() == 0) begin
        flag($sformatf("unexpected result kind %0d chunk %h/%0d sym %0h left %0h",
                       got.result_kind, got.chunk_bits, got.chunk_len,
                       got.symbol_out, got.symbols_left));
        return;
      end
      want = due_results.pop_front();
      cmp_field("result_kind",  want.result_kind,  got.result_kind);
      cmp_field("chunk_bits",   want.chunk_bits,   got.chunk_bits);
      cmp_field("chunk_len",    want.chunk_len,    got.chunk_len);
      cmp_field("last_chunk",   want.last_chunk,   got.last_chunk);
      cmp_field("symbol_out",   want.symbol_out,   got.symbol_out);
      cmp_field("symbols_left", want.symbols_left, got.symbols_left);
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  hufc_pkg::in_item_t  in_item   = '0;
  logic                out_stall = 1'b0;
  logic                cfg_valid = 1'b0;
  hufc_pkg::count_t    cfg_data  = '0;
  logic                in_stall;
  logic                out_valid;
  hufc_pkg::out_item_t out_item;
  logic                cfg_ready;

  codec_tracker tracker = new();
  bit           quiet = 1'b0;
  int           items_done = 0;
  int           stall_left = 0;
  int unsigned  cycle_count = 0;

  huffman_table_codec_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Mostly short idles, now and then a long one
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Check accepted results and stall the result channel at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_result(out_item);
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("huffman_table_codec_core verification failed");
      $finish;
    end
  end

  function automatic hufc_pkg::in_item_t junk_item();
    hufc_pkg::in_item_t it;
    it.action    = 2'($urandom_range(0, 3));
    it.symbol    = 8'($urandom_range(0, 255));
    it.code_bits = $urandom();
    it.code_len  = 6'($urandom_range(0, 63));
    it.bit_in    = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Present one transaction and hold it until accepted
  task automatic push_item(input hufc_pkg::in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    if (!(it.action == hufc_pkg::ACT_BIT && tracker.left == '0)) items_done++;
    tracker.take_item(it);
  endtask

  task automatic send_load(input hufc_pkg::sym_field_t s, input hufc_pkg::code_t bits,
                           input hufc_pkg::len_t n);
    hufc_pkg::in_item_t it;
    it = junk_item();
    it.action    = hufc_pkg::ACT_LOAD;
    it.symbol    = s;
    it.code_bits = bits;
    it.code_len  = n;
    push_item(it);
  endtask

  task automatic send_encode(input hufc_pkg::sym_field_t s);
    hufc_pkg::in_item_t it;
    it = junk_item();
    it.action = hufc_pkg::ACT_ENCODE;
    it.symbol = s;
    push_item(it);
  endtask

  task automatic send_start();
    hufc_pkg::in_item_t it;
    it = junk_item();
    it.action = hufc_pkg::ACT_START;
    push_item(it);
  endtask

  task automatic send_bit(input logic b);
    hufc_pkg::in_item_t it;
    it = junk_item();
    it.action = hufc_pkg::ACT_BIT;
    it.bit_in = b;
    push_item(it);
  endtask

  // Hold off the sender until every predicted result has arrived
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
  endtask

  // Write the symbol count once the codec has gone quiet
  task automatic write_count(input hufc_pkg::count_t value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.run_count = value;
  endtask

  // One round: fresh prefix-free table, some encodes, then a decode run
  task automatic run_round(input bit force_gap);
    int               n_sym;
    int               k;
    int               len_pick;
    int               top_len;
    int               i;
    int               j;
    int               b;
    int               r;
    longint unsigned  used;
    longint unsigned  next_code;
    int               lens [$];
    hufc_pkg::sym_t   syms [$];
    hufc_pkg::code_t  codes [$];
    bit               taken [hufc_pkg::TABLE_DEPTH];
    bit               gap_top;
    hufc_pkg::count_t cnt;
    hufc_pkg::sym_t   s;
    quiet   = ($urandom_range(0, 4) == 0);
    gap_top = force_gap || ($urandom_range(0, 5) == 0);
    top_len = gap_top ? hufc_pkg::CODE_W - 1 : hufc_pkg::CODE_W;
    k       = $urandom_range(1, 8);

    // pick the run length, extremes included
    r = $urandom_range(0, 9);
    if (force_gap)   cnt = '1;
    else if (r == 0) cnt = '0;
    else if (r == 1) cnt = hufc_pkg::count_t'(1);
    else if (r == 2) cnt = '1;
    else if (r == 3) cnt = $urandom();
    else if (r < 7)  cnt = hufc_pkg::count_t'(k);
    else if (r == 7) cnt = hufc_pkg::count_t'(k - 1);
    else             cnt = hufc_pkg::count_t'(k + 2);
    write_count(cnt);

    // code lengths within the Kraft budget, kept sorted
    n_sym = $urandom_range(2, 10);
    used  = 0;
    for (i = 0; i < n_sym; i++) begin
      len_pick = ($urandom_range(0, 7) == 0) ? $urandom_range(7, top_len)
                                             : $urandom_range(1, 6);
      while (len_pick <= top_len &&
             used + (64'd1 << (32 - len_pick)) > (64'd1 << 32)) len_pick++;
      if (len_pick > top_len) break;
      used += 64'd1 << (32 - len_pick);
      j = 0;
      while (j < lens.size() && lens[j] <= len_pick) j++;
      lens.insert(j, len_pick);
    end
    foreach (lens[x]) begin
      do s = hufc_pkg::sym_t'($urandom_range(0, 255)); while (taken[s]);
      taken[s] = 1'b1;
      syms = {syms, s};
    end

    // canonical codes, optionally pushed down so nothing starts with a one
    next_code = 0;
    foreach (lens[x]) begin
      codes = {codes, hufc_pkg::code_t'(next_code)};
      next_code += 64'd1 << (32 - lens[x]);
    end
    if (gap_top) begin
      foreach (lens[x]) begin
        codes[x] = codes[x] >> 1;
        lens[x]++;
      end
    end

    // drop every live entry outside the new set
    for (i = 0; i < hufc_pkg::TABLE_DEPTH; i++) begin
      if (tracker.code_len_tab[i] != '0 && !taken[i])
        send_load(hufc_pkg::sym_field_t'(i), $urandom(), '0);
    end
    foreach (syms[x]) begin
      send_load(syms[x],
                codes[x] | ($urandom_range(0, 1) ?
                            (hufc_pkg::code_t'($urandom()) >> lens[x]) : '0),
                (lens[x] == hufc_pkg::CODE_W && $urandom_range(0, 1)) ?
                  hufc_pkg::len_t'($urandom_range(33, 63)) : hufc_pkg::len_t'(lens[x]));
    end

    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 5) == 0)
        send_encode(hufc_pkg::sym_field_t'($urandom_range(0, 255)));
      else
        send_encode(syms[$urandom_range(0, syms.size() - 1)]);
    end
    if ($urandom_range(0, 3) == 0) drain();

    // feed a well-formed message with the odd encode or restart mixed in
    send_start();
    for (i = 0; i < k; i++) begin
      j = $urandom_range(0, syms.size() - 1);
      for (b = 0; b < lens[j]; b++) begin
        send_bit(codes[j][hufc_pkg::CODE_W-1-b]);
        if ($urandom_range(0, 11) == 0) send_encode(syms[$urandom_range(0, syms.size() - 1)]);
        if (!force_gap && $urandom_range(0, 79) == 0) send_start();
      end
    end

    // steer into the unused half of the code space to force an overflow
    if (gap_top) begin
      send_bit(1'b1);
      repeat (hufc_pkg::CODE_W - 1) send_bit(1'($urandom_range(0, 1)));
    end else if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 8)) send_bit(1'($urandom_range(0, 1)));
    end

    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(4, 12)) push_item(junk_item());
    end
  endtask

  initial begin
    bit first;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: absent symbol, exhausted count, load edge cases, chunking
    write_count('0);
    send_encode(8'h05);
    send_start();
    send_bit(1'b1);
    send_load(8'hFF, 32'hFFFF_FFFF, 6'd63);
    send_load(8'h00, 32'hA5A5_A5A5, 6'd17);
    send_load(8'h7E, 32'h1234_FFFF, 6'd16);
    send_encode(8'h00);
    send_encode(8'hFF);
    send_encode(8'h7E);
    send_load(8'h01, 32'h8000_0000, 6'd1);
    send_load(8'h02, 32'h0000_0000, 6'd2);
    send_load(8'h03, 32'h4000_0000, 6'd2);
    // same code on a higher symbol, which should win the match
    send_load(8'hC8, 32'h4000_0000, 6'd2);
    send_encode(8'h01);
    write_count('1);
    send_start();
    send_bit(1'b1);
    send_bit(1'b0);
    send_bit(1'b1);
    send_bit(1'b0);
    send_bit(1'b0);

    // random rounds
    items_done = 0;
    first      = 1'b1;
    while (items_done < RANDOM_ITEMS) begin
      run_round(first);
      first = 1'b0;
    end

    quiet = 1'b0;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.due_results.size() != 0)
      tracker.flag($sformatf("%0d results never arrived", tracker.due_results.size()));
    if (tracker.faults == 0) begin
      $display("huffman_table_codec_core verification clean");
    end else begin
      $display("huffman_table_codec_core verification failed");
    end
    $finish;
  end

endmodule
